// ===== rtl/core/bzr_pkg.sv =====
// Shared constants, types and the parameter lookup table of the cubic Bezier point evaluator.
package bzr_pkg;

  localparam int Steps      = 200;
  localparam int NumRegs    = 8;
  localparam int CfgIdxW    = $clog2(NumRegs);
  localparam int CoordW     = 12;
  localparam int StepW      = 8;
  localparam int PointW     = 16;
  localparam int UW         = 16;
  localparam int VW         = UW + 1;
  localparam int WgtW       = 3 * UW + 1;
  localparam int ProdW      = 62;
  localparam int FracShift  = 44;
  localparam int TabDepth   = 2 ** StepW;

  // Pipeline stage positions
  localparam int NumStages  = 6;
  localparam int StgParam   = 0;
  localparam int StgSquare  = 1;
  localparam int StgCube    = 2;
  localparam int StgProd    = 3;
  localparam int StgPair    = 4;
  localparam int StgRound   = 5;

  typedef enum logic [CfgIdxW-1:0] {
    RegX0, RegX1, RegX2, RegX3,
    RegY0, RegY1, RegY2, RegY3
  } cfg_reg_e;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [NumStages-1:0]     stage_en_t;

  typedef struct packed {
    logic [WgtW-1:0] w0;
    logic [WgtW-1:0] w1;
    logic [WgtW-1:0] w2;
    logic [WgtW-1:0] w3;
  } weights_t;

  typedef logic [UW-1:0] utab_t [TabDepth];

  // u = round(k / Steps) in Q0.16, k saturated to Steps - 1
  function automatic utab_t build_utab();
    utab_t  tab;
    longint kk;
    for (int i = 0; i < TabDepth; i++) begin
      kk     = (i >= Steps) ? longint'(Steps - 1) : longint'(i);
      tab[i] = UW'((kk * 65536 + Steps / 2) / Steps);
    end
    return tab;
  endfunction

  localparam utab_t UTab = build_utab();

  localparam logic signed [ProdW-1:0] RoundBias = ProdW'(64'sd1 <<< (FracShift - 1));

endpackage

// ===== rtl/core/cubic_bezier_point_evaluator.sv =====
// Top level of the cubic Bezier point evaluator.
//
//  channel  direction  handshake               payload
//  in       input      in_valid_i/in_stall_o   step_index_i
//  out      output     out_valid_o/out_stall_i point_x_o, point_y_o
//  cfg      input      cfg_we_i                cfg_idx_i, cfg_data_i
//
// Six register stages: u lookup, squares, cubes, products, pair sums, final sum/round.
// One transaction per cycle while the output is not stalled; products are split into 12x25 and 12x24 halves.
// Reset clears the control points and the stage valid bits.
// A stalled output holds the last stage; earlier stages keep filling bubbles.
module cubic_bezier_point_evaluator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bzr_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [bzr_pkg::CoordW-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [bzr_pkg::StepW-1:0]           step_index_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [bzr_pkg::PointW-1:0]   point_x_o,
  output logic signed [bzr_pkg::PointW-1:0]   point_y_o
);

  bzr_pkg::coord_t    ctrl_x [4];
  bzr_pkg::coord_t    ctrl_y [4];
  bzr_pkg::stage_en_t en;
  bzr_pkg::weights_t  wgt;

  bzr_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .ctrl_x_o   (ctrl_x),
    .ctrl_y_o   (ctrl_y)
  );

  bzr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .en_o        (en)
  );

  bzr_weights u_weights (
    .clk_i        (clk_i),
    .en_i         (en),
    .step_index_i (step_index_i),
    .wgt_o        (wgt)
  );

  bzr_blend u_blend_x (
    .clk_i   (clk_i),
    .en_i    (en),
    .p_i     (ctrl_x),
    .wgt_i   (wgt),
    .point_o (point_x_o)
  );

  bzr_blend u_blend_y (
    .clk_i   (clk_i),
    .en_i    (en),
    .p_i     (ctrl_y),
    .wgt_i   (wgt),
    .point_o (point_y_o)
  );

endmodule

// ===== rtl/core/bzr_cfg.sv =====
// Control point register file.
module bzr_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bzr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bzr_pkg::CoordW-1:0]    cfg_data_i,
  output bzr_pkg::coord_t               ctrl_x_o [4],
  output bzr_pkg::coord_t               ctrl_y_o [4]
);

  bzr_pkg::coord_t regs_q [bzr_pkg::NumRegs];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bzr_pkg::NumRegs; i++) begin
        regs_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (bzr_pkg::cfg_reg_e'(cfg_idx_i))
        bzr_pkg::RegX0: regs_q[bzr_pkg::RegX0] <= cfg_data_i;
        bzr_pkg::RegX1: regs_q[bzr_pkg::RegX1] <= cfg_data_i;
        bzr_pkg::RegX2: regs_q[bzr_pkg::RegX2] <= cfg_data_i;
        bzr_pkg::RegX3: regs_q[bzr_pkg::RegX3] <= cfg_data_i;
        bzr_pkg::RegY0: regs_q[bzr_pkg::RegY0] <= cfg_data_i;
        bzr_pkg::RegY1: regs_q[bzr_pkg::RegY1] <= cfg_data_i;
        bzr_pkg::RegY2: regs_q[bzr_pkg::RegY2] <= cfg_data_i;
        bzr_pkg::RegY3: regs_q[bzr_pkg::RegY3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign ctrl_x_o[0] = regs_q[bzr_pkg::RegX0];
  assign ctrl_x_o[1] = regs_q[bzr_pkg::RegX1];
  assign ctrl_x_o[2] = regs_q[bzr_pkg::RegX2];
  assign ctrl_x_o[3] = regs_q[bzr_pkg::RegX3];
  assign ctrl_y_o[0] = regs_q[bzr_pkg::RegY0];
  assign ctrl_y_o[1] = regs_q[bzr_pkg::RegY1];
  assign ctrl_y_o[2] = regs_q[bzr_pkg::RegY2];
  assign ctrl_y_o[3] = regs_q[bzr_pkg::RegY3];

endmodule

// ===== rtl/core/bzr_ctrl.sv =====
// Pipeline valid tracking and per-stage advance enables.
module bzr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bzr_pkg::stage_en_t  en_o
);

  localparam int Last = bzr_pkg::NumStages - 1;

  bzr_pkg::stage_en_t valid_q;
  bzr_pkg::stage_en_t en;

  // A stage may load when it is empty or its contents move on
  always_comb begin
    en[Last] = !valid_q[Last] || !out_stall_i;
    for (int s = Last - 1; s >= 0; s--) begin
      en[s] = !valid_q[s] || en[s+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int s = 1; s <= Last; s++) begin
        if (en[s]) begin
          valid_q[s] <= valid_q[s-1];
        end
      end
    end
  end

  assign en_o        = en;
  assign in_stall_o  = !en[0];
  assign out_valid_o = valid_q[Last];

endmodule

// ===== rtl/core/bzr_weights.sv =====
// Parameter lookup and Bernstein weight stages (u, squares, cubes).
module bzr_weights (
  input  logic                       clk_i,
  input  bzr_pkg::stage_en_t         en_i,
  input  logic [bzr_pkg::StepW-1:0]  step_index_i,
  output bzr_pkg::weights_t          wgt_o
);

  logic [bzr_pkg::UW-1:0]     u1_q, u2_q;
  logic [bzr_pkg::VW-1:0]     v1_q, v2_q;
  logic [2*bzr_pkg::UW:0]     vsq_q;
  logic [2*bzr_pkg::UW-1:0]   usq_q;
  bzr_pkg::weights_t          wgt_q;

  logic [bzr_pkg::UW-1:0]     u_lut;
  logic [2*bzr_pkg::UW+bzr_pkg::VW:0] w0_full;
  logic [2*bzr_pkg::UW+bzr_pkg::UW:0] w1_full;
  logic [2*bzr_pkg::UW+bzr_pkg::VW-1:0] w2_full;
  logic [3*bzr_pkg::UW-1:0]   w3_full;

  assign u_lut   = bzr_pkg::UTab[step_index_i];
  assign w0_full = vsq_q * v2_q;
  assign w1_full = vsq_q * u2_q;
  assign w2_full = usq_q * v2_q;
  assign w3_full = usq_q * u2_q;

  always_ff @(posedge clk_i) begin
    if (en_i[bzr_pkg::StgParam]) begin
      u1_q <= u_lut;
      v1_q <= (bzr_pkg::VW'(1) << bzr_pkg::UW) - {1'b0, u_lut};
    end
    if (en_i[bzr_pkg::StgSquare]) begin
      u2_q  <= u1_q;
      v2_q  <= v1_q;
      vsq_q <= v1_q * v1_q;
      usq_q <= u1_q * u1_q;
    end
    if (en_i[bzr_pkg::StgCube]) begin
      wgt_q.w0 <= w0_full[bzr_pkg::WgtW-1:0];
      wgt_q.w1 <= w1_full[bzr_pkg::WgtW-1:0];
      wgt_q.w2 <= w2_full[bzr_pkg::WgtW-1:0];
      wgt_q.w3 <= bzr_pkg::WgtW'(w3_full);
    end
  end

  assign wgt_o = wgt_q;

endmodule

// ===== rtl/core/bzr_blend.sv =====
// Weighted sum of four coordinates and rounding to Q12.4, one axis.
module bzr_blend (
  input  logic                               clk_i,
  input  bzr_pkg::stage_en_t                 en_i,
  input  bzr_pkg::coord_t                    p_i [4],
  input  bzr_pkg::weights_t                  wgt_i,
  output logic signed [bzr_pkg::PointW-1:0]  point_o
);

  localparam int PW   = bzr_pkg::ProdW;
  localparam int LoW  = 25;
  localparam int HiW  = bzr_pkg::WgtW - LoW;
  localparam int LoPW = bzr_pkg::CoordW + LoW + 1;
  localparam int HiPW = bzr_pkg::CoordW + HiW + 1;

  logic [bzr_pkg::WgtW-1:0] w_sel [4];
  logic signed [LoPW-1:0] lo_q [4];
  logic signed [HiPW-1:0] hi_q [4];
  logic signed [PW-1:0] lo_ext [4];
  logic signed [PW-1:0] hi_ext [4];
  logic signed [PW-1:0] a_q, b_q;
  logic signed [PW-1:0] acc;
  logic signed [bzr_pkg::PointW-1:0] point_q;

  always_comb begin
    w_sel[0] = wgt_i.w0;
    w_sel[1] = wgt_i.w1;
    w_sel[2] = wgt_i.w2;
    w_sel[3] = wgt_i.w3;
    for (int i = 0; i < 4; i++) begin
      lo_ext[i] = PW'(lo_q[i]);
      hi_ext[i] = PW'(hi_q[i]) <<< LoW;
    end
  end

  // inner terms carry the factor 3: b + 2b
  assign acc = a_q + b_q + (b_q <<< 1) + bzr_pkg::RoundBias;

  always_ff @(posedge clk_i) begin
    if (en_i[bzr_pkg::StgProd]) begin
      for (int i = 0; i < 4; i++) begin
        lo_q[i] <= p_i[i] * $signed({1'b0, w_sel[i][LoW-1:0]});
        hi_q[i] <= p_i[i] * $signed({1'b0, w_sel[i][bzr_pkg::WgtW-1:LoW]});
      end
    end
    if (en_i[bzr_pkg::StgPair]) begin
      a_q <= lo_ext[0] + hi_ext[0] + lo_ext[3] + hi_ext[3];
      b_q <= lo_ext[1] + hi_ext[1] + lo_ext[2] + hi_ext[2];
    end
    if (en_i[bzr_pkg::StgRound]) begin
      point_q <= acc[bzr_pkg::FracShift+bzr_pkg::PointW-1:bzr_pkg::FracShift];
    end
  end

  assign point_o = point_q;

endmodule
